FILE: design/mmn_pkg.sv
// ----------------------------------------------------------------------------
// mmn_pkg
// Shared types for the min-max normalisation block.
// ----------------------------------------------------------------------------
package mmn_pkg;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_DONE
  } back_state_e;

  typedef enum logic {
    OP_MEASURE   = 1'b0,
    OP_NORMALIZE = 1'b1
  } op_e;

  typedef struct packed {
    logic degenerate;
    logic last;
  } ctrl_t;

endpackage

FILE: design/mmn_fifo.sv
// ----------------------------------------------------------------------------
// mmn_fifo
// Two-entry request queue between the front and the back part.
// ----------------------------------------------------------------------------
module mmn_fifo #(
  parameter int Width = 34
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [Width-1:0] pop_data_o
);

  logic [Width-1:0] mem_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       count_q, count_d;

  assign full_o     = (count_q == 2'd2);
  assign valid_o    = (count_q != 2'd0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    count_d  = count_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

FILE: design/mmn_front.sv
// ----------------------------------------------------------------------------
// mmn_front
// Accepts requests, tracks the running extremes and prepares the numerator,
// denominator and flags of each normalise request.
// ----------------------------------------------------------------------------
module mmn_front #(
  parameter int SampleBits = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         accept_i,
  input  logic                         op_i,
  input  logic signed [SampleBits-1:0] sample_i,
  input  logic                         last_i,
  output logic                         push_o,
  output logic [SampleBits-1:0]        num_o,
  output logic [SampleBits-1:0]        den_o,
  output mmn_pkg::ctrl_t               ctrl_o
);

  logic signed [SampleBits-1:0] min_q, min_d;
  logic signed [SampleBits-1:0] max_q, max_d;
  logic                         closed_q, closed_d;
  logic signed [SampleBits-1:0] clamped;
  logic        [SampleBits:0]   num_wide;
  logic        [SampleBits:0]   den_wide;
  logic                         degen;
  logic                         is_measure;

  assign is_measure = (mmn_pkg::op_e'(op_i) == mmn_pkg::OP_MEASURE);

  always_comb begin
    min_d    = min_q;
    max_d    = max_q;
    closed_d = closed_q;
    if (accept_i && is_measure) begin
      if (closed_q) begin
        min_d = sample_i;
        max_d = sample_i;
      end else begin
        if (sample_i > max_q) begin
          max_d = sample_i;
        end
        if (sample_i < min_q) begin
          min_d = sample_i;
        end
      end
      closed_d = last_i;
    end
  end

  always_comb begin
    degen = (max_q <= min_q);
    priority if (sample_i < min_q) begin
      clamped = min_q;
    end else if (sample_i > max_q) begin
      clamped = max_q;
    end else begin
      clamped = sample_i;
    end
    num_wide = {clamped[SampleBits-1], clamped} - {min_q[SampleBits-1], min_q};
    den_wide = {max_q[SampleBits-1], max_q} - {min_q[SampleBits-1], min_q};
  end

  assign push_o            = accept_i && !is_measure;
  assign num_o             = degen ? '0 : num_wide[SampleBits-1:0];
  assign den_o             = degen ? '0 : den_wide[SampleBits-1:0];
  assign ctrl_o.degenerate = degen;
  assign ctrl_o.last       = last_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q    <= {1'b0, {(SampleBits-1){1'b1}}};
      max_q    <= {1'b1, {(SampleBits-1){1'b0}}};
      closed_q <= 1'b1;
    end else begin
      min_q    <= min_d;
      max_q    <= max_d;
      closed_q <= closed_d;
    end
  end

endmodule

FILE: design/mmn_back.sv
// ----------------------------------------------------------------------------
// mmn_back
// Restoring divider, one quotient bit per cycle, and the output register.
// ----------------------------------------------------------------------------
module mmn_back #(
  parameter int SampleBits   = 16,
  parameter int FractionBits = 15
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  input  logic [SampleBits-1:0]   num_i,
  input  logic [SampleBits-1:0]   den_i,
  input  mmn_pkg::ctrl_t          ctrl_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [FractionBits:0]   normalized_o,
  output logic                    degenerate_o,
  output logic                    end_of_image_o
);

  localparam int CntBits = $clog2(FractionBits + 1);

  mmn_pkg::back_state_e state_q, state_d;
  logic [SampleBits-1:0]   rem_q, rem_d;
  logic [SampleBits-1:0]   den_q, den_d;
  logic [FractionBits:0]   quo_q, quo_d;
  logic [CntBits-1:0]      cnt_q, cnt_d;
  mmn_pkg::ctrl_t          ctrl_q, ctrl_d;
  logic                    out_valid_q, out_valid_d;
  logic [FractionBits:0]   norm_q, norm_d;
  logic                    degen_q, degen_d;
  logic                    eoi_q, eoi_d;
  logic [SampleBits:0]     shifted;
  logic [SampleBits:0]     diff;
  logic                    qbit;

  always_comb begin
    shifted = (cnt_q == '0) ? {1'b0, rem_q} : {rem_q, 1'b0};
    diff    = shifted - {1'b0, den_q};
    qbit    = !diff[SampleBits];
  end

  always_comb begin
    state_d     = state_q;
    rem_d       = rem_q;
    den_d       = den_q;
    quo_d       = quo_q;
    cnt_d       = cnt_q;
    ctrl_d      = ctrl_q;
    out_valid_d = out_valid_q && !out_ready_i;
    norm_d      = norm_q;
    degen_d     = degen_q;
    eoi_d       = eoi_q;
    pop_o       = 1'b0;
    unique case (state_q)
      mmn_pkg::BK_IDLE: begin
        if (valid_i) begin
          pop_o   = 1'b1;
          rem_d   = num_i;
          den_d   = den_i;
          ctrl_d  = ctrl_i;
          cnt_d   = '0;
          state_d = mmn_pkg::BK_DIV;
        end
      end
      mmn_pkg::BK_DIV: begin
        quo_d = {quo_q[FractionBits-1:0], qbit};
        rem_d = qbit ? diff[SampleBits-1:0] : shifted[SampleBits-1:0];
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntBits'(FractionBits)) begin
          state_d = mmn_pkg::BK_DONE;
        end
      end
      mmn_pkg::BK_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          norm_d      = ctrl_q.degenerate ? '0 : quo_q;
          degen_d     = ctrl_q.degenerate;
          eoi_d       = ctrl_q.last;
          state_d     = mmn_pkg::BK_IDLE;
        end
      end
      default: begin
        state_d = mmn_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mmn_pkg::BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q   <= rem_d;
    den_q   <= den_d;
    quo_q   <= quo_d;
    cnt_q   <= cnt_d;
    ctrl_q  <= ctrl_d;
    norm_q  <= norm_d;
    degen_q <= degen_d;
    eoi_q   <= eoi_d;
  end

  assign out_valid_o    = out_valid_q;
  assign normalized_o   = norm_q;
  assign degenerate_o   = degen_q;
  assign end_of_image_o = eoi_q;

endmodule

FILE: design/min_max_normalize.sv
// ----------------------------------------------------------------------------
// min_max_normalize
// Global min-max normalisation of an image that is streamed twice.
// ----------------------------------------------------------------------------
// The input channel carries op, sample and last. A measure request (op 0)
// updates the running minimum and maximum; last closes the pass, and the
// next measure request starts a new one. Measure requests give no result.
// A normalise request (op 1) gives one result: (x-min)/(max-min) as an
// unsigned fixed-point fraction, saturated to 0 .. 1.0, with degenerate set
// and the value 0 when max is not greater than min.
// Measure requests are taken one per cycle while the two-entry queue has
// room. The back part works on one normalise request at a time: it takes
// the request from the queue, runs the bit-serial divider and then loads
// the output register, and only then takes the next one. When the
// receiver stalls, the result waits in the output register, the divider
// holds its finished quotient and the queue fills, after which
// in_ready_o drops. Reset empties the queue and the output register and
// restores the extremes to their empty values.
// ----------------------------------------------------------------------------
module min_max_normalize #(
  parameter int SAMPLE_BITS   = 16,
  parameter int FRACTION_BITS = 15
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          op_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic                          last_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [FRACTION_BITS:0]        normalized_o,
  output logic                          degenerate_o,
  output logic                          end_of_image_o
);

  localparam int CtrlBits  = $bits(mmn_pkg::ctrl_t);
  localparam int EntryBits = 2 * SAMPLE_BITS + CtrlBits;

  logic                   accept;
  logic                   push;
  logic                   full;
  logic                   pop;
  logic                   q_valid;
  logic [SAMPLE_BITS-1:0] f_num;
  logic [SAMPLE_BITS-1:0] f_den;
  mmn_pkg::ctrl_t         f_ctrl;
  logic [EntryBits-1:0]   q_data;
  mmn_pkg::ctrl_t         b_ctrl;

  assign in_ready_o = !full;
  assign accept     = in_valid_i && in_ready_o;

  mmn_front #(
    .SampleBits(SAMPLE_BITS)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .op_i    (op_i),
    .sample_i(sample_i),
    .last_i  (last_i),
    .push_o  (push),
    .num_o   (f_num),
    .den_o   (f_den),
    .ctrl_o  (f_ctrl)
  );

  mmn_fifo #(
    .Width(EntryBits)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i({f_num, f_den, f_ctrl}),
    .full_o     (full),
    .pop_i      (pop),
    .valid_o    (q_valid),
    .pop_data_o (q_data)
  );

  assign b_ctrl = mmn_pkg::ctrl_t'(q_data[CtrlBits-1:0]);

  mmn_back #(
    .SampleBits  (SAMPLE_BITS),
    .FractionBits(FRACTION_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (q_valid),
    .num_i         (q_data[EntryBits-1 -: SAMPLE_BITS]),
    .den_i         (q_data[CtrlBits +: SAMPLE_BITS]),
    .ctrl_i        (b_ctrl),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .normalized_o  (normalized_o),
    .degenerate_o  (degenerate_o),
    .end_of_image_o(end_of_image_o)
  );

endmodule

FILE: design/mmn_checker.sv
// ----------------------------------------------------------------------------
// mmn_checker
// Port-level checks for the min-max normalisation block.
// ----------------------------------------------------------------------------
module mmn_checker #(
  parameter int FractionBits = 15
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  out_valid_i,
  input logic                  out_ready_i,
  input logic [FractionBits:0] normalized_i,
  input logic                  degenerate_i,
  input logic                  end_of_image_i
);

  localparam logic [FractionBits:0] One = {1'b1, {FractionBits{1'b0}}};

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(normalized_i)
      && $stable(degenerate_i) && $stable(end_of_image_i))
    else $error("Result changed while stalled.");

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && degenerate_i |-> normalized_i == '0)
    else $error("Degenerate result is not zero.");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> normalized_i <= One)
    else $error("Normalised value exceeds one.");

endmodule

bind min_max_normalize mmn_checker #(
  .FractionBits(FRACTION_BITS)
) u_mmn_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .normalized_i  (normalized_o),
  .degenerate_i  (degenerate_o),
  .end_of_image_i(end_of_image_o)
);
